// ----- rtl/core/mhc_pkg.sv -----
// Shared constants, tables and helper functions for the compass heading unit.
// Used by the divider, the CORDIC engine and the top level; no dependencies.
`default_nettype none
package mhc_pkg;

	// Default parameter values.
	localparam int MHC_CORDIC_STEPS = 16;
	localparam int MHC_SCALE_FRAC   = 14;

	// CORDIC geometry.
	localparam int ATAN_DEPTH = 24;
	localparam int PRESHIFT   = 8;
	localparam int CORDIC_XW  = 28;

	// Magnitude limit of a scaled axis, and the positive limit.
	localparam logic [16:0] SCALE_LIMIT_NEG = 17'd32768;
	localparam logic [16:0] SCALE_LIMIT_POS = 17'd32767;

	// Input item modes.
	localparam logic [1:0] MODE_MEASURE = 2'd0;
	localparam logic [1:0] MODE_CLEAR   = 2'd1;
	localparam logic [1:0] MODE_SAMPLE  = 2'd2;

	// Reset values of the calibration store and the declination.
	localparam logic signed [15:0] LOW_X_RST  = -16'sd566;
	localparam logic signed [15:0] HIGH_X_RST = 16'sd651;
	localparam logic signed [15:0] LOW_Y_RST  = -16'sd685;
	localparam logic signed [15:0] HIGH_Y_RST = 16'sd526;
	localparam logic signed [15:0] LOW_Z_RST  = -16'sd447;
	localparam logic signed [15:0] HIGH_Z_RST = 16'sd684;
	localparam logic signed [15:0] DECL_RST   = 16'sd106;

	// atan(2^-i) in units of full circle over 2^32.
	localparam logic [31:0] ATAN_TAB [ATAN_DEPTH] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// Saturate an 18-bit signed value to 16 bits.
	function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
		logic signed [15:0] r;
		if (v > 18'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -18'sd32768) begin
			r = -16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/mhc_divider.sv -----
// Bit-serial restoring divider: one quotient bit per cycle, magnitude capped.
// Depends on mhc_pkg for the quotient limit.
`default_nettype none
module mhc_divider #(
	parameter int DW = 33
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [16:0]   divisor,
	output logic               done,
	output logic [16:0]        quotient
);
	import mhc_pkg::*;

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] dvd_q;
	logic [16:0]   rem_q;
	logic [16:0]   quo_q;
	logic          ovf_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [17:0] rem_sh;
	logic [17:0] diff;
	logic        qbit;

	// Trial subtraction of the divisor from the shifted remainder.
	always_comb begin
		rem_sh = {rem_q, dvd_q[DW-1]};
		diff   = rem_sh - {1'b0, divisor};
		qbit   = (rem_sh >= {1'b0, divisor});
	end

	// Control: count the dividend bits through.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift the dividend out and the quotient in.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			rem_q <= qbit ? diff[16:0] : rem_sh[16:0];
			quo_q <= {quo_q[15:0], qbit};
			ovf_q <= ovf_q | quo_q[16];
		end
	end

	assign done     = done_q;
	assign quotient = (ovf_q || quo_q > SCALE_LIMIT_NEG) ? SCALE_LIMIT_NEG : quo_q;

endmodule
`default_nettype wire

// ----- rtl/core/mhc_cordic.sv -----
// Iterative CORDIC in vectoring mode: one micro-rotation per cycle, atan2(y, x).
// Depends on mhc_pkg for the arctangent table and datapath widths.
`default_nettype none
module mhc_cordic #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [15:0] qx,
	input  wire logic signed [15:0] qy,
	output logic                    done,
	output logic [15:0]             angle
);
	import mhc_pkg::*;

	localparam int ST = (CORDIC_STEPS > ATAN_DEPTH) ? ATAN_DEPTH : CORDIC_STEPS;
	localparam int IW = $clog2(ATAN_DEPTH);

	logic signed [CORDIC_XW-1:0] x_q, y_q;
	logic [31:0]                 ang_q;
	logic [IW-1:0]               idx_q;
	logic                        busy_q;
	logic                        done_q;

	logic signed [CORDIC_XW-1:0] x0, y0, dx, dy;
	logic [31:0]                 ang_sum;

	// Pre-shifted start vector and the shifted terms of one rotation.
	always_comb begin
		x0 = {{(CORDIC_XW-16-PRESHIFT){qx[15]}}, qx, {PRESHIFT{1'b0}}};
		y0 = {{(CORDIC_XW-16-PRESHIFT){qy[15]}}, qy, {PRESHIFT{1'b0}}};
		dx = y_q >>> idx_q;
		dy = x_q >>> idx_q;
		ang_sum = ang_q + 32'h0000_8000;
	end

	// Control: step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == IW'(ST - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: fold into the right half plane, then rotate toward the x axis.
	always_ff @(posedge clk) begin
		if (start) begin
			if (x0 < 0) begin
				x_q   <= -x0;
				y_q   <= -y0;
				ang_q <= 32'h8000_0000;
			end else begin
				x_q   <= x0;
				y_q   <= y0;
				ang_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q >= 0) begin
				x_q   <= x_q + dx;
				y_q   <= y_q - dy;
				ang_q <= ang_q + ATAN_TAB[idx_q];
			end else begin
				x_q   <= x_q - dx;
				y_q   <= y_q + dy;
				ang_q <= ang_q - ATAN_TAB[idx_q];
			end
		end
	end

	assign done  = done_q;
	assign angle = ang_sum[31:16];

endmodule
`default_nettype wire

// ----- rtl/core/magnetometer_heading_with_calibration_unit.sv -----
// Compass heading with hard-iron calibration. Clear and calibration-sample
// transactions are applied as they are accepted. A measure transaction runs
// through the three parallel bit-serial dividers, then the CORDIC, then the
// control states; the CORDIC is skipped when an axis has a zero range. The next
// item is accepted in the cycle after the result is loaded; a result still
// waiting downstream holds the sequencer. Reset restores the extremes and the
// declination to their defaults and empties the output register.
// Depends on mhc_pkg, mhc_divider and mhc_cordic.
`default_nettype none
module magnetometer_heading_with_calibration_unit #(
	parameter int CORDIC_STEPS        = mhc_pkg::MHC_CORDIC_STEPS,
	parameter int SCALE_FRACTION_BITS = mhc_pkg::MHC_SCALE_FRAC
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [15:0]  cfg_wdata,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// x_high, x_low, z_high, z_low, y_high, y_low
	input  wire logic [47:0]  s_axis_tdata,
	// mode
	input  wire logic [1:0]   s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// heading_angle, heading_degrees, heading_minutes, scaled_x, scaled_y,
	// scaled_z, centered_x, centered_y, centered_z, zero pad
	output logic [127:0]      m_axis_tdata,
	// scale_valid
	output logic [0:0]        m_axis_tuser
);
	import mhc_pkg::*;

	localparam int DW = SCALE_FRACTION_BITS + 19;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DSTART = 3'd1;
	localparam logic [2:0] ST_DIV    = 3'd2;
	localparam logic [2:0] ST_CSTART = 3'd3;
	localparam logic [2:0] ST_CORD   = 3'd4;
	localparam logic [2:0] ST_HEAD   = 3'd5;
	localparam logic [2:0] ST_PROD   = 3'd6;
	localparam logic [2:0] ST_HOLD   = 3'd7;

	logic [2:0] state_q;

	logic signed [15:0] decl_q;
	logic signed [15:0] low_x_q, high_x_q, low_y_q, high_y_q, low_z_q, high_z_q;
	logic signed [15:0] cx_q, cy_q, cz_q;
	logic signed [15:0] sx_q, sy_q, sz_q;
	logic               valid_q;
	logic [15:0]        raw_q;
	logic [15:0]        head_q;
	logic [24:0]        prod_q;
	logic [127:0]       out_data_q;
	logic               out_user_q;
	logic               out_valid_q;

	logic               in_acc;
	logic signed [15:0] rx, ry, rz;
	logic [15:0]        gx, gy, gz;
	logic [16:0]        gx_w, gy_w, gz_w;
	logic [15:0]        ax, ay, az;
	logic               div_done;
	logic               div_done_y;
	logic               div_done_z;
	logic [16:0]        qx_mag, qy_mag, qz_mag;
	logic               cor_done;
	logic [15:0]        cor_angle;
	logic [22:0]        mins_w;

	// Midpoint truncated toward zero, then the saturated difference.
	function automatic logic signed [15:0] center(input logic signed [15:0] r,
		input logic signed [15:0] lo, input logic signed [15:0] hi);
		logic signed [16:0] s;
		logic signed [16:0] mid;
		s   = 17'(lo) + 17'(hi);
		mid = (s + $signed({16'd0, s[16]})) >>> 1;
		return sat16(18'(r) - 18'(mid));
	endfunction

	// Apply the sign and the one-sided limit to a quotient magnitude.
	function automatic logic signed [15:0] signed_q(input logic [16:0] mag,
		input logic neg);
		logic [16:0] m;
		m = (!neg && mag > SCALE_LIMIT_POS) ? SCALE_LIMIT_POS : mag;
		return neg ? -m[15:0] : m[15:0];
	endfunction

	function automatic logic [15:0] abs16(input logic signed [15:0] v);
		return v[15] ? 16'(-v) : 16'(v);
	endfunction

	// Input unpacking and axis ranges.
	always_comb begin
		in_acc = s_axis_tvalid && s_axis_tready;
		rx     = {s_axis_tdata[7:0], s_axis_tdata[15:8]};
		rz     = {s_axis_tdata[23:16], s_axis_tdata[31:24]};
		ry     = {s_axis_tdata[39:32], s_axis_tdata[47:40]};
		gx_w   = 17'(high_x_q) - 17'(low_x_q);
		gy_w   = 17'(high_y_q) - 17'(low_y_q);
		gz_w   = 17'(high_z_q) - 17'(low_z_q);
		gx     = gx_w[15:0];
		gy     = gy_w[15:0];
		gz     = gz_w[15:0];
		ax     = abs16(cx_q);
		ay     = abs16(cy_q);
		az     = abs16(cz_q);
		mins_w = 23'(prod_q[15:0]) * 23'd60 + 23'd32768;
	end

	assign s_axis_tready = (state_q == ST_IDLE);

	// Three dividers work in step on the three axes.
	mhc_divider #(.DW(DW)) u_div_x (
		.clk(clk), .arst_n(arst_n), .start(state_q == ST_DSTART),
		.dividend(DW'({ax, {(SCALE_FRACTION_BITS+2){1'b0}}}) + DW'(gx)),
		.divisor({gx, 1'b0}), .done(div_done), .quotient(qx_mag)
	);
	mhc_divider #(.DW(DW)) u_div_y (
		.clk(clk), .arst_n(arst_n), .start(state_q == ST_DSTART),
		.dividend(DW'({ay, {(SCALE_FRACTION_BITS+2){1'b0}}}) + DW'(gy)),
		.divisor({gy, 1'b0}), .done(div_done_y), .quotient(qy_mag)
	);
	mhc_divider #(.DW(DW)) u_div_z (
		.clk(clk), .arst_n(arst_n), .start(state_q == ST_DSTART),
		.dividend(DW'({az, {(SCALE_FRACTION_BITS+2){1'b0}}}) + DW'(gz)),
		.divisor({gz, 1'b0}), .done(div_done_z), .quotient(qz_mag)
	);

	mhc_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(state_q == ST_CSTART),
		.qx(sx_q), .qy(sy_q), .done(cor_done), .angle(cor_angle)
	);

	// Declination register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decl_q <= DECL_RST;
		end else if (cfg_we) begin
			decl_q <= cfg_wdata;
		end
	end

	// Calibration extremes: cleared or widened as transactions arrive.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_x_q  <= LOW_X_RST;
			high_x_q <= HIGH_X_RST;
			low_y_q  <= LOW_Y_RST;
			high_y_q <= HIGH_Y_RST;
			low_z_q  <= LOW_Z_RST;
			high_z_q <= HIGH_Z_RST;
		end else if (in_acc && s_axis_tuser == MODE_CLEAR) begin
			low_x_q  <= '0;
			high_x_q <= '0;
			low_y_q  <= '0;
			high_y_q <= '0;
			low_z_q  <= '0;
			high_z_q <= '0;
		end else if (in_acc && s_axis_tuser == MODE_SAMPLE) begin
			if (rx < low_x_q)  low_x_q  <= rx;
			if (rx > high_x_q) high_x_q <= rx;
			if (ry < low_y_q)  low_y_q  <= ry;
			if (ry > high_y_q) high_y_q <= ry;
			if (rz < low_z_q)  low_z_q  <= rz;
			if (rz > high_z_q) high_z_q <= rz;
		end
	end

	// Sequencer for a measure transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_HOLD && (!out_valid_q || m_axis_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && s_axis_tuser == MODE_MEASURE) begin
						state_q <= ST_DSTART;
					end
				end
				ST_DSTART: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						state_q <= valid_q ? ST_CSTART : ST_HEAD;
					end
				end
				ST_CSTART: state_q <= ST_CORD;
				ST_CORD: begin
					if (cor_done) begin
						state_q <= ST_HEAD;
					end
				end
				ST_HEAD: state_q <= ST_PROD;
				ST_PROD: state_q <= ST_HOLD;
				ST_HOLD: begin
					if (!out_valid_q || m_axis_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers of a measure transaction.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc) begin
			cx_q <= center(rx, low_x_q, high_x_q);
			cy_q <= center(ry, low_y_q, high_y_q);
			cz_q <= center(rz, low_z_q, high_z_q);
		end
		if (state_q == ST_DSTART) begin
			valid_q <= (gx != 16'd0) && (gy != 16'd0) && (gz != 16'd0);
		end
		if (state_q == ST_DIV && div_done) begin
			sx_q  <= valid_q ? signed_q(qx_mag, cx_q[15]) : 16'sd0;
			sy_q  <= valid_q ? signed_q(qy_mag, cy_q[15]) : 16'sd0;
			sz_q  <= valid_q ? signed_q(qz_mag, cz_q[15]) : 16'sd0;
			raw_q <= '0;
		end
		if (state_q == ST_CORD && cor_done) begin
			raw_q <= (sx_q == 16'sd0 && sy_q == 16'sd0) ? 16'd0 : cor_angle;
		end
		if (state_q == ST_HEAD) begin
			head_q <= valid_q ? raw_q + decl_q : 16'd0;
		end
		if (state_q == ST_PROD) begin
			prod_q <= 25'(head_q) * 25'd360;
		end
		if (state_q == ST_HOLD && (!out_valid_q || m_axis_tready)) begin
			out_data_q <= {1'b0, cz_q, cy_q, cx_q, sz_q, sy_q, sx_q,
				mins_w[21:16], prod_q[24:16], head_q};
			out_user_q <= valid_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	// The stored extremes never cross.
	a_order_x: assert property (@(posedge clk) disable iff (!arst_n)
		low_x_q <= high_x_q) else $error("X extremes crossed");
	a_order_y: assert property (@(posedge clk) disable iff (!arst_n)
		low_y_q <= high_y_q) else $error("Y extremes crossed");
	a_order_z: assert property (@(posedge clk) disable iff (!arst_n)
		low_z_q <= high_z_q) else $error("Z extremes crossed");
	// Unit completions arrive only while the sequencer waits for them.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV) else $error("divider done out of turn");
	a_cor_done: assert property (@(posedge clk) disable iff (!arst_n)
		cor_done |-> state_q == ST_CORD) else $error("CORDIC done out of turn");
	// The three dividers finish together.
	a_div_step: assert property (@(posedge clk) disable iff (!arst_n)
		(div_done_y == div_done) && (div_done_z == div_done))
		else $error("dividers out of step");

endmodule
`default_nettype wire
